@@ src/dlfd_pkg.sv @@
// ----------------------------------------------------------------------------
// dlfd_pkg: shared types and constants for the display link frame decoder
// Frame check record, status codes, command addresses and event flag bits.
// ----------------------------------------------------------------------------
package dlfd_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_HEAD  = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_CRC   = 2'd3
    } status_t;

    // Frame summary handed from the tracker to the command decoder
    typedef struct packed {
        status_t     status;
        logic [15:0] addr;
        logic [7:0]  pw_hi;
        logic [7:0]  value;
    } frame_chk_t;

    localparam logic [7:0]  HDR0          = 8'h5A;
    localparam logic [7:0]  HDR1          = 8'hA5;
    localparam logic [7:0]  HEAD_DEPTH    = 8'd9;
    localparam logic [7:0]  CRC_START_IDX = 8'd5;
    localparam logic [7:0]  LAST_IDX_MIN  = 8'd8;
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic [15:0] ADDR_PAGE      = 16'h5000;
    localparam logic [15:0] ADDR_SET_FIRST = 16'h500B;
    localparam logic [15:0] ADDR_SET_LAST  = 16'h5019;
    localparam logic [15:0] ADDR_ZOOM      = 16'h501A;
    localparam logic [15:0] ADDR_PRINT     = 16'h501B;
    localparam logic [15:0] ADDR_DOWNLOAD  = 16'h501C;
    localparam logic [15:0] ADDR_ZSTEP     = 16'h501D;
    localparam logic [15:0] ADDR_QUIT      = 16'h501E;
    localparam logic [15:0] ADDR_FAULT     = 16'h501F;
    localparam logic [15:0] ADDR_PASSWORD  = 16'h519A;

    localparam logic [7:0] PAGE_PASSWORD = 8'd2;
    localparam logic [7:0] PAGE_FAULT    = 8'd5;
    localparam logic [7:0] PAGE_ZOOM     = 8'd6;
    localparam logic [7:0] ZSTEP_UP      = 8'd1;
    localparam logic [7:0] ZSTEP_DOWN    = 8'd2;

    localparam logic [9:0] EV_CHANGE   = 10'h001;
    localparam logic [9:0] EV_CLEAR    = 10'h002;
    localparam logic [9:0] EV_ZOOM     = 10'h004;
    localparam logic [9:0] EV_UP       = 10'h008;
    localparam logic [9:0] EV_DOWN     = 10'h010;
    localparam logic [9:0] EV_QUIT     = 10'h020;
    localparam logic [9:0] EV_FAULT    = 10'h040;
    localparam logic [9:0] EV_PRINT    = 10'h080;
    localparam logic [9:0] EV_DOWNLOAD = 10'h100;
    localparam logic [9:0] EV_PASS     = 10'h200;

    localparam logic [4:0] SET_SLOT_BIAS = 5'd10;

    localparam int PADDR_W = 3;
    localparam logic PW_REG_IDX = 1'b0;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ src/dlfd_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// dlfd_frame_tracker: per-byte frame capture and check
// Counts bytes, keeps the frame head, runs the CRC two bytes behind the
// stream and registers one check record at each frame end.
// ----------------------------------------------------------------------------
module dlfd_frame_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                byte_valid,
    input  logic [7:0]          rx_byte,
    input  logic                frame_end,
    output logic                chk_valid,
    output dlfd_pkg::frame_chk_t chk
);
    import dlfd_pkg::*;

    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  head_reg [HEAD_DEPTH];
    logic [7:0]  head_next [HEAD_DEPTH];
    logic [7:0]  dly0_reg, dly1_reg;
    logic        chk_valid_reg;
    frame_chk_t  chk_reg, chk_next;
    logic [15:0] crc_fed;
    logic        crc_ok;
    logic        accept;

    assign accept = byte_valid && advance;

    always_comb begin
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_next[i] = (count_reg == 8'(i)) ? rx_byte : head_reg[i];
        end
        crc_fed = (count_reg >= CRC_START_IDX) ? crc16_feed(crc_reg, dly0_reg) : crc_reg;
        crc_ok  = (dly1_reg == crc_fed[7:0]) && (rx_byte == crc_fed[15:8]);

        if (frame_end) begin
            count_next = '0;
            crc_next   = CRC_INIT;
        end else begin
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
            crc_next   = crc_fed;
        end

        if (count_reg < LAST_IDX_MIN || head_next[0] != HDR0 || head_next[1] != HDR1) begin
            chk_next.status = ST_BAD_HEAD;
        end else if (count_reg == COUNT_MAX ||
                     {1'b0, count_reg} != {1'b0, head_next[2]} + 9'd2) begin
            chk_next.status = ST_BAD_LEN;
        end else if (!crc_ok) begin
            chk_next.status = ST_BAD_CRC;
        end else begin
            chk_next.status = ST_OK;
        end
        chk_next.addr  = {head_next[4], head_next[5]};
        chk_next.pw_hi = head_next[7];
        chk_next.value = head_next[8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            chk_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
            end
            if (advance) begin
                chk_valid_reg <= accept && frame_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= head_next[i];
            end
            dly0_reg <= dly1_reg;
            dly1_reg <= rx_byte;
            if (frame_end) begin
                chk_reg <= chk_next;
            end
        end
    end

    assign chk_valid = chk_valid_reg;
    assign chk       = chk_reg;

    a_restart_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |=> count_reg == '0 && crc_reg == CRC_INIT)
        else $error("frame state not restarted after frame end");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !frame_end && count_reg == COUNT_MAX |=> count_reg == COUNT_MAX)
        else $error("byte count wrapped");

endmodule

@@ src/dlfd_cmd_decoder.sv @@
// ----------------------------------------------------------------------------
// dlfd_cmd_decoder: command decode and result register
// Applies an accepted frame's address to the display state and builds the
// result word.
// ----------------------------------------------------------------------------
module dlfd_cmd_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 chk_valid,
    input  dlfd_pkg::frame_chk_t chk,
    input  logic [15:0]          password_value,
    output logic                 res_valid,
    output logic [55:0]          res_data
);
    import dlfd_pkg::*;

    logic [7:0] page_reg, page_next;
    logic [7:0] zoom_area_reg, zoom_area_next;
    logic [7:0] zoom_step_reg, zoom_step_next;
    logic [7:0] fault_record_reg, fault_record_next;
    logic [9:0] flags;
    logic [3:0] slot;
    logic [7:0] sval;
    logic       res_valid_reg;
    logic [55:0] res_data_reg;

    always_comb begin
        page_next         = page_reg;
        zoom_area_next    = zoom_area_reg;
        zoom_step_next    = zoom_step_reg;
        fault_record_next = fault_record_reg;
        flags = '0;
        slot  = '0;
        sval  = '0;
        if (chk.status == ST_OK) begin
            if (chk.addr >= ADDR_SET_FIRST && chk.addr <= ADDR_SET_LAST) begin
                slot = 4'(chk.addr[4:0] - SET_SLOT_BIAS);
                sval = chk.value;
            end
            case (chk.addr)
                ADDR_PAGE: begin
                    page_next = chk.value;
                    flags     = EV_CHANGE | EV_CLEAR;
                end
                ADDR_ZOOM: begin
                    page_next      = PAGE_ZOOM;
                    zoom_area_next = chk.value;
                    flags          = EV_CHANGE | EV_ZOOM | EV_CLEAR;
                end
                ADDR_ZSTEP: begin
                    zoom_step_next = chk.value;
                    if (chk.value == ZSTEP_UP) begin
                        flags = EV_UP;
                    end else if (chk.value == ZSTEP_DOWN) begin
                        flags = EV_DOWN;
                    end
                end
                ADDR_QUIT: begin
                    page_next = PAGE_FAULT;
                    flags     = EV_CHANGE | EV_CLEAR | EV_QUIT;
                end
                ADDR_FAULT: begin
                    fault_record_next = chk.value;
                    page_next         = PAGE_FAULT;
                    flags             = EV_CHANGE | EV_FAULT;
                end
                ADDR_PRINT:    flags = EV_PRINT;
                ADDR_DOWNLOAD: flags = EV_DOWNLOAD;
                ADDR_PASSWORD: begin
                    if ({chk.pw_hi, chk.value} == password_value) begin
                        page_next = PAGE_PASSWORD;
                        flags     = EV_PASS | EV_CHANGE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg         <= '0;
            zoom_area_reg    <= '0;
            zoom_step_reg    <= '0;
            fault_record_reg <= '0;
            res_valid_reg    <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= chk_valid;
            if (chk_valid) begin
                page_reg         <= page_next;
                zoom_area_reg    <= zoom_area_next;
                zoom_step_reg    <= zoom_step_next;
                fault_record_reg <= fault_record_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && chk_valid) begin
            res_data_reg <= {sval, slot, fault_record_next, zoom_step_next,
                             zoom_area_next, page_next, flags, chk.status};
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_reject_no_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && chk_valid && chk.status != ST_OK |=>
            res_data[11:2] == '0 && res_data[47:44] == '0 && res_data[19:12] == page_reg)
        else $error("rejected frame produced an action");

    a_check_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && chk_valid |=> res_valid)
        else $error("frame check lost before result register");

endmodule

@@ src/display_link_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// display_link_frame_decoder: serial display link frame receiver
// Checks header, length and CRC-16/MODBUS of each frame and decodes the
// command address of accepted frames into display state and event flags.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_*      | in        | one received byte, tlast on the frame's last byte
//  m_*      | out       | one result per frame end
//  apb      | in        | password register at byte address 0
//
//  One byte per cycle sustained while a held result is not stalled by m_tready.
//  A frame's result passes the tracker register, then the result register.
//  Reset is synchronous on aresetn low; display state and counters clear.
//  A stalled m_tready holds the result and stops s_tready; nothing is lost.
// ----------------------------------------------------------------------------
module display_link_frame_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: rx_byte[7:0]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tlast,
    // m_tdata: status[1:0], event_flags[11:2], page_number[19:12],
    //          zoom_area[27:20], zoom_step[35:28], fault_record[43:36],
    //          setting_slot[47:44], setting_value[55:48]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [55:0]                  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dlfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dlfd_pkg::*;

    logic        advance;
    logic        chk_valid;
    frame_chk_t  chk;
    logic [15:0] password_reg;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            password_reg <= 16'd6666;
        end else if (psel && penable && pwrite && paddr[2] == PW_REG_IDX) begin
            password_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == PW_REG_IDX) ? {16'h0000, password_reg} : 32'h0;

    dlfd_frame_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .byte_valid (s_tvalid),
        .rx_byte    (s_tdata),
        .frame_end  (s_tlast),
        .chk_valid  (chk_valid),
        .chk        (chk)
    );

    dlfd_cmd_decoder u_decoder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .chk_valid      (chk_valid),
        .chk            (chk),
        .password_value (password_reg),
        .res_valid      (m_tvalid),
        .res_data       (m_tdata)
    );

    a_no_accept_while_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result blocked");

endmodule
